@@ hw/rtl/framed_packet_receive_crc_check_top_macros.svh @@
// assertion macros shared by the checker
`ifndef FRAMED_PACKET_RECEIVE_CRC_CHECK_TOP_MACROS_SVH
`define FRAMED_PACKET_RECEIVE_CRC_CHECK_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define FPCRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define FPCRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/fpcrc_pkg.sv @@
`timescale 1ns / 1ps

package fpcrc_pkg;

  // defaults
  localparam int DEF_MAX_PAYLOAD = 64;
  localparam logic [7:0] DEF_START_BYTE = 8'h02;
  localparam logic [15:0] DEF_CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_CRC_SEED = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [5:0] packet_length;
    logic [1:0] source_channel;
    logic       crc_error;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic bind_ch;
    logic unbind_ch;
    logic clr_err;
    logic load_len;
    logic store;
    logic chk_lo;
    logic chk_hi;
    logic mem_rd;
    logic out_load;
    logic rd_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic same_ch;
    logic len_ok;
    logic data_ok;
    logic fill_last;
    logic rd_last;
    logic out_free;
  } sts_t;

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/framed_packet_receive_crc_check_top.sv @@
`timescale 1ns / 1ps
// Framed packet receiver with CRC-16 check.
// Input channel (item_valid/item_ready, item): one received byte per transaction,
// tagged with its channel. A frame is four start bytes, a length byte, the payload
// and the CRC-16 low then high byte, all on one channel.
// Output channel (result_valid/result_ready, result): one payload byte per
// transaction with index, length, channel, CRC error flag and last marker.
// Frame bytes are taken one per cycle while no replay runs. The CRC high byte
// starts the replay of the stored payload: each result takes a payload buffer
// read, then a result register load, and the input is held until the last
// result is loaded. item_ready is low during replay.
// A stalled receiver holds the result register and the replay waits; the last
// result can wait in the register while the next frame is already coming in.
// Registers over the APB port: start byte at 0x0, CRC seed at 0x4; write only
// while idle. Reset (rst, synchronous) returns to waiting for a start byte,
// drops any pending result and restores start byte 0x02 and seed 0xFFFF.
module framed_packet_receive_crc_check_top #(
  parameter int MAX_PAYLOAD = fpcrc_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  fpcrc_pkg::in_item_t                item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output fpcrc_pkg::out_item_t               result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fpcrc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fpcrc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fpcrc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);

  logic [7:0]      start_byte;
  logic [15:0]     crc_seed;
  fpcrc_pkg::cmd_t cmd;
  fpcrc_pkg::sts_t sts;

  // configuration registers
  fpcrc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_byte (start_byte),
    .crc_seed   (crc_seed)
  );

  // frame and replay sequencing
  fpcrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // frame registers, crc, payload buffer, result register
  fpcrc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .start_byte   (start_byte),
    .crc_seed     (crc_seed),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

@@ hw/rtl/fpcrc_regs.sv @@
`timescale 1ns / 1ps

module fpcrc_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fpcrc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fpcrc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fpcrc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready,
  output logic [7:0]                            start_byte,
  output logic [15:0]                           crc_seed
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= fpcrc_pkg::DEF_START_BYTE;
      crc_seed   <= fpcrc_pkg::DEF_CRC_SEED;
    end else if (wr_en) begin
      case (reg_idx)
        fpcrc_pkg::REG_START_BYTE: start_byte <= pwdata[7:0];
        fpcrc_pkg::REG_CRC_SEED:   crc_seed   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      fpcrc_pkg::REG_START_BYTE: prdata = {24'h000000, start_byte};
      fpcrc_pkg::REG_CRC_SEED:   prdata = {16'h0000, crc_seed};
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/fpcrc_ctrl.sv @@
`timescale 1ns / 1ps

module fpcrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fpcrc_pkg::sts_t   sts,
  output fpcrc_pkg::cmd_t   cmd
);

  // frame phases, then the replay steps
  localparam logic [3:0] S_SOF1 = 4'd0;
  localparam logic [3:0] S_SOF2 = 4'd1;
  localparam logic [3:0] S_SOF3 = 4'd2;
  localparam logic [3:0] S_SOF4 = 4'd3;
  localparam logic [3:0] S_LEN  = 4'd4;
  localparam logic [3:0] S_DATA = 4'd5;
  localparam logic [3:0] S_CRCL = 4'd6;
  localparam logic [3:0] S_CRCH = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_LD   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  // bytes are taken only while parsing and out of reset
  assign item_ready = !rst && !state[3];
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_SOF1: begin
        if (accept && sts.is_start) begin
          cmd.bind_ch = 1'b1;
          cmd.clr_err = 1'b1;
          state_next  = S_SOF2;
        end
      end
      S_SOF2, S_SOF3, S_SOF4, S_LEN, S_DATA, S_CRCL, S_CRCH: begin
        if (accept) begin
          if (!sts.same_ch
              || (state == S_LEN && !sts.len_ok)
              || (state == S_DATA && !sts.data_ok)
              || (state != S_LEN && state != S_DATA && state != S_CRCL
                  && state != S_CRCH && !sts.is_start)) begin
            // abort, a start byte opens a new frame
            if (sts.is_start) begin
              cmd.bind_ch = 1'b1;
              state_next  = S_SOF2;
            end else begin
              cmd.unbind_ch = 1'b1;
              state_next    = S_SOF1;
            end
          end else begin
            case (state)
              S_LEN: begin
                cmd.load_len = 1'b1;
                state_next   = S_DATA;
              end
              S_DATA: begin
                cmd.store = 1'b1;
                if (sts.fill_last) begin
                  state_next = S_CRCL;
                end
              end
              S_CRCL: begin
                cmd.chk_lo = 1'b1;
                state_next = S_CRCH;
              end
              S_CRCH: begin
                cmd.chk_hi = 1'b1;
                state_next = S_RD;
              end
              default: state_next = state + 4'd1;
            endcase
          end
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.rd_last) begin
            cmd.clr_err = 1'b1;
            state_next  = S_SOF1;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      default: state_next = S_SOF1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SOF1;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/fpcrc_dp.sv @@
`timescale 1ns / 1ps

module fpcrc_dp #(
  parameter int MAX_PAYLOAD = fpcrc_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpcrc_pkg::in_item_t    item,
  input  logic [7:0]             start_byte,
  input  logic [15:0]            crc_seed,
  input  fpcrc_pkg::cmd_t        cmd,
  output fpcrc_pkg::sts_t        sts,
  output fpcrc_pkg::out_item_t   result,
  output logic                   result_valid,
  input  logic                   result_ready
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD);
  localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD);

  logic [1:0]       bound_channel;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] fill_index;
  logic [LEN_W-1:0] rd_idx;
  logic [15:0]      running_crc;
  logic             error_flag;
  logic [7:0]       rd_data;
  logic [7:0]       payload_store [MAX_PAYLOAD];
  logic [LEN_W:0]   fill_inc;
  logic [LEN_W:0]   rd_inc;

  assign fill_inc = {1'b0, fill_index} + 1'b1;
  assign rd_inc   = {1'b0, rd_idx} + 1'b1;

  // status toward the controller
  always_comb begin
    sts.is_start  = (item.rx_byte == start_byte);
    sts.same_ch   = (item.channel == bound_channel);
    sts.len_ok    = (item.rx_byte != 8'h00) && ({1'b0, item.rx_byte} < LEN_LIMIT);
    sts.data_ok   = (fill_index < expected_length);
    sts.fill_last = (fill_inc >= {1'b0, expected_length});
    sts.rd_last   = (rd_inc >= {1'b0, expected_length});
    sts.out_free  = !result_valid || result_ready;
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_channel   <= '0;
      expected_length <= '0;
      fill_index      <= '0;
      rd_idx          <= '0;
      running_crc     <= fpcrc_pkg::DEF_CRC_SEED;
      error_flag      <= 1'b0;
    end else begin
      if (cmd.bind_ch) begin
        bound_channel <= item.channel;
      end else if (cmd.unbind_ch) begin
        bound_channel <= '0;
      end
      if (cmd.clr_err) begin
        error_flag <= 1'b0;
      end else if (cmd.chk_lo && item.rx_byte != running_crc[7:0]) begin
        error_flag <= 1'b1;
      end else if (cmd.chk_hi && item.rx_byte != running_crc[15:8]) begin
        error_flag <= 1'b1;
      end
      if (cmd.load_len) begin
        expected_length <= item.rx_byte[LEN_W-1:0];
        fill_index      <= '0;
        running_crc     <= crc_seed;
      end else if (cmd.store) begin
        running_crc <= fpcrc_pkg::crc_step(running_crc, item.rx_byte);
        fill_index  <= sts.fill_last ? '0 : fill_inc[LEN_W-1:0];
      end
      if (cmd.chk_hi) begin
        rd_idx <= '0;
      end else if (cmd.rd_next) begin
        rd_idx <= rd_inc[LEN_W-1:0];
      end
    end
  end

  // payload buffer
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      payload_store[fill_index] <= item.rx_byte;
    end
    if (cmd.mem_rd) begin
      rd_data <= payload_store[rd_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.payload_byte   <= rd_data;
      result.byte_index     <= 6'(rd_idx);
      result.packet_length  <= 6'(expected_length);
      result.source_channel <= bound_channel;
      result.crc_error      <= error_flag;
      result.last           <= sts.rd_last;
    end
  end

endmodule

@@ hw/rtl/fpcrc_checker.sv @@
`timescale 1ns / 1ps
`include "framed_packet_receive_crc_check_top_macros.svh"

module fpcrc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input fpcrc_pkg::out_item_t result
);

  // no result survives reset
  `FPCRC_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid, "result valid after reset")

  // input stays closed until the last byte of a packet is out
  `FPCRC_ASSERT(a_replay_blocks_input, (result_valid && !result.last) |-> !item_ready, "byte taken during replay")

  // last byte sits at the end of the packet
  `FPCRC_ASSERT(a_last_index, (result_valid && result.last) |-> (6'(result.byte_index + 6'd1) == result.packet_length), "last flag at wrong index")

  // stalled result holds
  `FPCRC_ASSERT(a_result_holds, (result_valid && !result_ready) |=> (result_valid && $stable(result)), "stalled result changed")

endmodule

bind framed_packet_receive_crc_check_top fpcrc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import fpcrc_pkg::*;

  localparam int MAX_LEN = DEF_MAX_PAYLOAD;
  // longest replay of one packet, plus margin
  localparam int REPLAY_CYCLES = 2 * MAX_LEN + 20;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_SOF1, PH_SOF2, PH_SOF3, PH_SOF4, PH_LEN, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } rx_phase_e;

  // deframer predictor and the payload bytes still due from the block
  class packet_scoreboard;
    logic [7:0]  start_val;
    logic [15:0] seed;
    rx_phase_e   phase;
    logic [1:0]  bound_ch;
    logic [5:0]  frame_len;
    logic [5:0]  fill_pos;
    logic [15:0] crc_acc;
    logic        crc_bad;
    logic [7:0]  payload_buf [MAX_LEN];
    out_item_t   payload_due [$];
    int          mismatches;

    function new();
      start_val = DEF_START_BYTE;
      seed = DEF_CRC_SEED;
      phase = PH_SOF1;
      bound_ch = '0;
      frame_len = '0;
      fill_pos = '0;
      crc_acc = DEF_CRC_SEED;
      crc_bad = 1'b0;
      mismatches = 0;
    endfunction

    // crc-16, poly 0x1021, msb first, one byte
    static function logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [7:0]  x;
      logic [15:0] w;
      x = crc[15:8] ^ b;
      x = x ^ (x >> 4);
      w = {8'h00, x};
      return {crc[7:0], 8'h00} ^ (w << 12) ^ (w << 5) ^ w;
    endfunction

    // wrong byte: a start byte restarts the frame on its channel, anything else goes idle
    function void drop_frame(logic [7:0] b, logic [1:0] ch);
      if (b == start_val) begin
        bound_ch = ch;
        phase = PH_SOF2;
      end else begin
        bound_ch = '0;
        phase = PH_SOF1;
      end
    endfunction

    // one accepted input transaction
    function void note_byte(in_item_t it);
      logic [7:0] b;
      logic [1:0] ch;
      logic       same;
      out_item_t  r;
      b = it.rx_byte;
      ch = it.channel;
      same = (ch == bound_ch);
      case (phase)
        PH_SOF1: begin
          if (b == start_val) begin
            bound_ch = ch;
            crc_bad = 1'b0;
            phase = PH_SOF2;
          end
        end
        PH_SOF2, PH_SOF3, PH_SOF4: begin
          if (b == start_val && same) phase = rx_phase_e'(phase + 1);
          else drop_frame(b, ch);
        end
        PH_LEN: begin
          if (b != 8'h00 && b < MAX_LEN && same) begin
            frame_len = b[5:0];
            fill_pos = '0;
            crc_acc = seed;
            phase = PH_DATA;
          end else begin
            drop_frame(b, ch);
          end
        end
        PH_DATA: begin
          if (same && fill_pos < frame_len) begin
            payload_buf[fill_pos] = b;
            crc_acc = crc16_next(crc_acc, b);
            if (fill_pos + 1 >= frame_len) begin
              fill_pos = '0;
              phase = PH_CRC_LO;
            end else begin
              fill_pos = fill_pos + 6'd1;
            end
          end else begin
            drop_frame(b, ch);
          end
        end
        PH_CRC_LO: begin
          if (same) begin
            if (b != crc_acc[7:0]) crc_bad = 1'b1;
            phase = PH_CRC_HI;
          end else begin
            drop_frame(b, ch);
          end
        end
        default: begin
          if (same) begin
            if (b != crc_acc[15:8]) crc_bad = 1'b1;
            phase = PH_SOF1;
            // replay the stored payload
            for (int k = 0; k < frame_len; k++) begin
              r.payload_byte = payload_buf[k];
              r.byte_index = 6'(k);
              r.packet_length = frame_len;
              r.source_channel = bound_ch;
              r.crc_error = crc_bad;
              r.last = (k + 1 == frame_len);
              payload_due.push_back(r);
            end
            crc_bad = 1'b0;
          end else begin
            drop_frame(b, ch);
          end
        end
      endcase
    endfunction

    function void report(string field, logic [7:0] exp_val, logic [7:0] got_val);
      $display("%0t: %s expected %0h got %0h", $time, field, exp_val, got_val);
      mismatches++;
    endfunction

    // one accepted output transaction against the oldest expected byte
    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (payload_due.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        mismatches++;
        return;
      end
      exp_item = payload_due.pop_front();
      if (got.payload_byte !== exp_item.payload_byte)
        report("payload_byte", exp_item.payload_byte, got.payload_byte);
      if (got.byte_index !== exp_item.byte_index)
        report("byte_index", exp_item.byte_index, got.byte_index);
      if (got.packet_length !== exp_item.packet_length)
        report("packet_length", exp_item.packet_length, got.packet_length);
      if (got.source_channel !== exp_item.source_channel)
        report("source_channel", exp_item.source_channel, got.source_channel);
      if (got.crc_error !== exp_item.crc_error)
        report("crc_error", exp_item.crc_error, got.crc_error);
      if (got.last !== exp_item.last)
        report("last", exp_item.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  in_item_t              item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  out_item_t             result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  packet_scoreboard sb;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit send_steady = 1'b0;

  framed_packet_receive_crc_check_top uut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reset
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("framed_packet_receive_crc_check_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver with random stalls
  initial begin : result_sink
    int gap;
    bit steady;
    steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      sb.check_result(result);
    end
  end

  // one input transaction after a random gap
  task automatic send_byte(input logic [7:0] b, input logic [1:0] ch);
    int gap;
    if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= in_item_t'{rx_byte: b, channel: ch};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  // apb write: setup then access cycle
  task automatic write_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (reg_idx == REG_START_BYTE) sb.start_val = value[7:0];
    else sb.seed = value[15:0];
  endtask

  // bring the block back to idle and wait out every replay
  task automatic settle();
    if (sb.phase != PH_SOF1) send_byte(~sb.start_val, sb.bound_ch + 2'd1);
    item_valid <= 1'b0;
    while (sb.payload_due.size() != 0) @(posedge clk);
    repeat (REPLAY_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] start_val, input logic [15:0] seed);
    settle();
    write_reg(REG_START_BYTE, APB_DATA_W'(start_val));
    write_reg(REG_CRC_SEED, APB_DATA_W'(seed));
  endtask

  // mostly well-formed frames with random content, some broken, some noise
  task automatic random_traffic(input int n_items);
    in_item_t    seq [$];
    in_item_t    stray;
    logic [15:0] crc;
    logic [7:0]  b;
    logic [1:0]  ch;
    int          stop_at;
    int          pick;
    int          flaw;
    int          len;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 12) begin
        // loose byte, often a start byte
        b = ($urandom_range(0, 3) == 0) ? sb.start_val : 8'($urandom);
        send_byte(b, 2'($urandom));
      end else begin
        seq.delete();
        ch = 2'($urandom);
        pick = $urandom_range(0, 99);
        len = (pick < 65) ? $urandom_range(1, 6) :
              (pick < 92) ? $urandom_range(7, 20) :
              (pick < 97) ? $urandom_range(21, MAX_LEN - 1) : MAX_LEN - 1;
        flaw = $urandom_range(0, 99);
        repeat (4) seq.push_back(in_item_t'{rx_byte: sb.start_val, channel: ch});
        // bad length byte
        if (flaw >= 94)
          b = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(MAX_LEN, 255));
        else
          b = 8'(len);
        seq.push_back(in_item_t'{rx_byte: b, channel: ch});
        crc = sb.seed;
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          seq.push_back(in_item_t'{rx_byte: b, channel: ch});
          crc = packet_scoreboard::crc16_next(crc, b);
        end
        // corrupted crc
        if (flaw >= 70 && flaw < 80) crc = crc ^ (16'd1 << $urandom_range(0, 15));
        seq.push_back(in_item_t'{rx_byte: crc[7:0], channel: ch});
        seq.push_back(in_item_t'{rx_byte: crc[15:8], channel: ch});
        if (flaw >= 80 && flaw < 87) begin
          // byte from another channel inside the frame
          stray.rx_byte = 8'($urandom);
          stray.channel = ch + 2'($urandom_range(1, 3));
          seq.insert($urandom_range(1, seq.size() - 1), stray);
        end else if (flaw >= 87 && flaw < 94) begin
          // frame cut short
          repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
        end
        foreach (seq[i]) send_byte(seq[i].rx_byte, seq[i].channel);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0]  s;
    logic [15:0] crc;
    sb = new();
    @(posedge clk);
    while (rst) @(posedge clk);

    s = sb.start_val;
    // loose bytes before any start byte are dropped
    send_byte(8'hFF, 2'd0);
    send_byte(8'h00, 2'd1);
    // start byte from another channel restarts the frame there
    send_byte(s, 2'd1);
    send_byte(s, 2'd2);
    // wrong start byte
    send_byte(s ^ 8'h01, 2'd2);
    // zero length
    repeat (4) send_byte(s, 2'd3);
    send_byte(8'h00, 2'd3);
    // crc low mismatch, then an aborting start byte keeps the error flag
    repeat (4) send_byte(s, 2'd3);
    send_byte(8'h01, 2'd3);
    send_byte(8'hFF, 2'd3);
    crc = packet_scoreboard::crc16_next(sb.seed, 8'hFF);
    send_byte(~crc[7:0], 2'd3);
    repeat (4) send_byte(s, 2'd0);
    send_byte(8'h01, 2'd0);
    send_byte(8'h00, 2'd0);
    crc = packet_scoreboard::crc16_next(sb.seed, 8'h00);
    send_byte(crc[7:0], 2'd0);
    send_byte(crc[15:8], 2'd0);

    random_traffic(60);
    reconfigure(8'h00, 16'h0000);
    random_traffic(60);
    reconfigure(8'hFF, 16'hFFFF);
    random_traffic(60);
    reconfigure(8'($urandom), 16'($urandom));
    random_traffic(45);
    reconfigure(DEF_START_BYTE, 16'h1D0F);
    random_traffic(30);
    settle();

    if (sb.mismatches == 0) begin
      $display("framed_packet_receive_crc_check_top test passed");
    end else begin
      $display("framed_packet_receive_crc_check_top test failed");
    end
    $finish;
  end

endmodule
